[sv/aaas_pkg.sv]
// shared types and constants for the altitude average and setpoint core
`timescale 1ns / 1ps
`default_nettype none

package aaas_pkg;

   // window and sensor scaling
   localparam int unsigned WINDOW_LEN = 10;
   localparam int unsigned ADC_SPAN   = 1241;
   localparam int unsigned PCT_SCALE  = 100;

   // field widths
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned DELTA_W    = 8;
   localparam int unsigned DESCENT_W  = 7;
   localparam int unsigned MEAN_W     = 12;
   localparam int unsigned PCT_W      = 10;
   localparam int unsigned SETPOINT_W = 8;
   localparam int unsigned ERROR_W    = 11;
   localparam int unsigned COUNT_W    = 10;

   // csr port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTITUDE_MAX   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_SAMPLES = 2'd1;
   localparam logic [SETPOINT_W-1:0]  ALTITUDE_MAX_RESET = 8'd100;
   localparam logic [COUNT_W-1:0]     SETTLE_RESET       = 10'd100;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SETPOINT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DESCEND  = 2'd2;

   // ring and running sum
   localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
   localparam int unsigned SUM_W  =
      $clog2(((1 << SAMPLE_W) - 1) * WINDOW_LEN + WINDOW_LEN / 2 + 1);

   // rounded mean: (sum + W/2) / W by reciprocal multiply
   localparam int unsigned MEAN_SHIFT  = 25;
   localparam longint unsigned MEAN_MUL =
      ((64'd1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int unsigned MEAN_MUL_W  = $clog2(MEAN_MUL + 1);
   localparam int unsigned MEAN_PROD_W = SUM_W + MEAN_MUL_W;

   // percent: |ref - mean| * 100 / ADC_SPAN by reciprocal multiply
   localparam int unsigned DIFF_W     = MEAN_W + 1;
   localparam int unsigned MAG_W      = $clog2((1 << MEAN_W) * PCT_SCALE);
   localparam int unsigned PCT_SHIFT  = 31;
   localparam longint unsigned PCT_MUL =
      ((64'd1 << PCT_SHIFT) + ADC_SPAN - 1) / ADC_SPAN;
   localparam int unsigned PCT_MUL_W  = $clog2(PCT_MUL + 1);
   localparam int unsigned PCT_PROD_W = MAG_W + PCT_MUL_W;
   localparam int unsigned PCT_POS_LIMIT = (1 << (PCT_W - 1)) - 1;
   localparam int unsigned PCT_NEG_LIMIT = 1 << (PCT_W - 1);
   localparam logic signed [PCT_W-1:0] PCT_POS_SAT = {1'b0, {(PCT_W-1){1'b1}}};
   localparam logic signed [PCT_W-1:0] PCT_NEG_SAT = {1'b1, {(PCT_W-1){1'b0}}};

   // request queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_SETPOINT,
      OP_DESCEND,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic [SAMPLE_W-1:0]         sample;
      logic signed [DELTA_W-1:0]   delta;
      logic [DESCENT_W-1:0]        descent;
   } item_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint;
      logic                  latched;
      logic                  latch_now;
      logic                  land_check;
   } ctl_type;

endpackage

`default_nettype wire

[sv/aaas_front.sv]
// request decode and queue push
`timescale 1ns / 1ps
`default_nettype none

module aaas_front (
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [aaas_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [aaas_pkg::SAMPLE_W-1:0]      req_sample_value,
   input  wire logic signed [aaas_pkg::DELTA_W-1:0] req_setpoint_delta,
   input  wire logic [aaas_pkg::DESCENT_W-1:0]     req_descent_amount,
   input  wire aaas_pkg::queue_status_type         q_status,
   output logic                                    push,
   output aaas_pkg::item_type                      push_item
);
   import aaas_pkg::*;

   op_type op;

   always_comb begin
      case (req_cmd)
         CMD_SAMPLE:   op = OP_SAMPLE;
         CMD_SETPOINT: op = OP_SETPOINT;
         CMD_DESCEND:  op = OP_DESCEND;
         default:      op = OP_NONE;
      endcase
   end

   assign req_ready         = !q_status.full;
   assign push              = req_valid && !q_status.full;
   assign push_item.op      = op;
   assign push_item.sample  = req_sample_value;
   assign push_item.delta   = req_setpoint_delta;
   assign push_item.descent = req_descent_amount;

endmodule

`default_nettype wire

[sv/aaas_queue.sv]
// short request queue between decode and execution
`timescale 1ns / 1ps
`default_nettype none

module aaas_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire aaas_pkg::item_type         push_item,
   input  wire logic                       pop,
   output logic                            pop_valid,
   output aaas_pkg::item_type              pop_item,
   output aaas_pkg::queue_status_type      status
);
   import aaas_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid    = (count_ff != '0);
   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

`default_nettype wire

[sv/aaas_back.sv]
// state update and result pipeline
`timescale 1ns / 1ps
`default_nettype none

module aaas_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [aaas_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [aaas_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                 pop_valid,
   input  wire aaas_pkg::item_type                   pop_item,
   output logic                                      pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [aaas_pkg::MEAN_W-1:0]               rsp_mean_level,
   output logic signed [aaas_pkg::PCT_W-1:0]         rsp_height_percent,
   output logic [aaas_pkg::SETPOINT_W-1:0]           rsp_target_height,
   output logic signed [aaas_pkg::ERROR_W-1:0]       rsp_height_error,
   output logic                                      rsp_landed,
   output logic                                      rsp_reference_ready
);
   import aaas_pkg::*;

   // configuration
   logic [SETPOINT_W-1:0] alt_max_ff;
   logic [COUNT_W-1:0]    settle_ff;

   // architectural state
   logic [SAMPLE_W-1:0]   ring_ff [WINDOW_LEN];
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_W-1:0]    seen_ff, seen_in;
   logic                  latched_ff, latched_in;
   logic [SETPOINT_W-1:0] setpoint_ff, setpoint_in;
   logic [MEAN_W-1:0]     ref_ff;

   // pipeline
   logic                  en;
   logic                  go;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   ctl_type               ctl_in, ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic [SUM_W-1:0]      sum_adj1_ff, sum_adj1_in;
   logic [MEAN_PROD_W-1:0] mean_prod2_ff, mean_prod2_in;
   logic [MEAN_PROD_W-1:0] mean_wide;
   logic [MEAN_W-1:0]     mean2;
   logic [MEAN_W-1:0]     ref_now;
   logic [MEAN_W-1:0]     mean3_ff, mean4_ff, mean5_ff;
   logic signed [DIFF_W-1:0] diff3_ff, diff3_in;
   logic [DIFF_W-1:0]     diff_abs;
   logic                  neg4_ff, neg5_ff;
   logic [MAG_W-1:0]      mag4_ff, mag4_in;
   logic [PCT_PROD_W-1:0] pct_prod5_ff, pct_prod5_in;
   logic [PCT_PROD_W-1:0] quot_wide;
   logic [MAG_W-1:0]      quot;
   logic [PCT_W-1:0]      quot_low;
   logic signed [PCT_W-1:0]   pct;
   logic signed [ERROR_W-1:0] err;

   // stage 0 working values
   logic [SAMPLE_W-1:0]       old_sample;
   logic [SUM_W-1:0]          sum_new;
   logic signed [COUNT_W-1:0] sp_sum;
   logic [SETPOINT_W-1:0]     sp_clamped;
   logic [SETPOINT_W-1:0]     sp_lowered;

   assign en  = !rsp_valid || rsp_ready;
   assign go  = en && pop_valid;
   assign pop = go;

   // ---------------- stage 0: state update ----------------
   always_comb begin
      old_sample = ring_ff[slot_ff];
      sum_new    = sum_ff - SUM_W'(old_sample) + SUM_W'(pop_item.sample);

      sp_sum = $signed({2'b00, setpoint_ff})
             + $signed({{(COUNT_W-DELTA_W){pop_item.delta[DELTA_W-1]}}, pop_item.delta});
      if (sp_sum >= $signed({2'b00, alt_max_ff})) begin
         sp_clamped = alt_max_ff;
      end else if (sp_sum < 0) begin
         sp_clamped = '0;
      end else begin
         sp_clamped = sp_sum[SETPOINT_W-1:0];
      end

      if (setpoint_ff > SETPOINT_W'(pop_item.descent)) begin
         sp_lowered = setpoint_ff - SETPOINT_W'(pop_item.descent);
      end else begin
         sp_lowered = '0;
      end

      slot_in     = slot_ff;
      sum_in      = sum_ff;
      seen_in     = seen_ff;
      latched_in  = latched_ff;
      setpoint_in = setpoint_ff;
      ctl_in.latch_now  = 1'b0;
      ctl_in.land_check = 1'b0;

      case (pop_item.op)
         OP_SAMPLE: begin
            sum_in  = sum_new;
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
            if (seen_ff < settle_ff) begin
               seen_in = seen_ff + 1'b1;
            end
            if (!latched_ff && seen_in >= settle_ff) begin
               latched_in       = 1'b1;
               ctl_in.latch_now = 1'b1;
            end
         end
         OP_SETPOINT: begin
            setpoint_in = sp_clamped;
         end
         OP_DESCEND: begin
            setpoint_in       = sp_lowered;
            ctl_in.land_check = (setpoint_ff == '0);
         end
         default: begin
         end
      endcase

      ctl_in.setpoint = setpoint_in;
      ctl_in.latched  = latched_in;
      sum_adj1_in     = sum_in + SUM_W'(WINDOW_LEN / 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_max_ff <= ALTITUDE_MAX_RESET;
         settle_ff  <= SETTLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALTITUDE_MAX:   alt_max_ff <= csr_wdata[SETPOINT_W-1:0];
            CSR_SETTLE_SAMPLES: settle_ff  <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff     <= '0;
         sum_ff      <= '0;
         seen_ff     <= '0;
         latched_ff  <= 1'b0;
         setpoint_ff <= '0;
      end else if (go) begin
         if (pop_item.op == OP_SAMPLE) begin
            ring_ff[slot_ff] <= pop_item.sample;
         end
         slot_ff     <= slot_in;
         sum_ff      <= sum_in;
         seen_ff     <= seen_in;
         latched_ff  <= latched_in;
         setpoint_ff <= setpoint_in;
      end
   end

   // ---------------- stages 1 to 5: mean, percent, error ----------------
   always_comb begin
      mean_prod2_in = MEAN_PROD_W'(sum_adj1_ff) * MEAN_PROD_W'(MEAN_MUL);

      mean_wide = mean_prod2_ff >> MEAN_SHIFT;
      mean2     = mean_wide[MEAN_W-1:0];
      ref_now   = ctl2_ff.latch_now ? mean2 : ref_ff;
      diff3_in  = $signed({1'b0, ref_now}) - $signed({1'b0, mean2});

      diff_abs = diff3_ff[DIFF_W-1] ? DIFF_W'(-diff3_ff) : DIFF_W'(diff3_ff);
      mag4_in  = MAG_W'(diff_abs) * MAG_W'(PCT_SCALE);

      pct_prod5_in = PCT_PROD_W'(mag4_ff) * PCT_PROD_W'(PCT_MUL);

      quot_wide = pct_prod5_ff >> PCT_SHIFT;
      quot      = quot_wide[MAG_W-1:0];
      quot_low  = quot[PCT_W-1:0];
      if (neg5_ff) begin
         pct = (quot > MAG_W'(PCT_NEG_LIMIT)) ? PCT_NEG_SAT : $signed(-quot_low);
      end else begin
         pct = (quot > MAG_W'(PCT_POS_LIMIT)) ? PCT_POS_SAT : $signed(quot_low);
      end
      err = $signed({{(ERROR_W-SETPOINT_W){1'b0}}, ctl5_ff.setpoint})
          - $signed({{(ERROR_W-PCT_W){pct[PCT_W-1]}}, pct});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         ref_ff    <= '0;
      end else if (en) begin
         v1_ff     <= go;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         rsp_valid <= v5_ff;
         if (v2_ff && ctl2_ff.latch_now) begin
            ref_ff <= mean2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl1_ff       <= ctl_in;
         sum_adj1_ff   <= sum_adj1_in;
         ctl2_ff       <= ctl1_ff;
         mean_prod2_ff <= mean_prod2_in;
         ctl3_ff       <= ctl2_ff;
         mean3_ff      <= mean2;
         diff3_ff      <= diff3_in;
         ctl4_ff       <= ctl3_ff;
         mean4_ff      <= mean3_ff;
         neg4_ff       <= diff3_ff[DIFF_W-1];
         mag4_ff       <= mag4_in;
         ctl5_ff       <= ctl4_ff;
         mean5_ff      <= mean4_ff;
         neg5_ff       <= neg4_ff;
         pct_prod5_ff  <= pct_prod5_in;
         rsp_mean_level      <= mean5_ff;
         rsp_height_percent  <= pct;
         rsp_target_height   <= ctl5_ff.setpoint;
         rsp_height_error    <= err;
         rsp_landed          <= ctl5_ff.land_check && (pct == '0);
         rsp_reference_ready <= ctl5_ff.latched;
      end
   end

endmodule

`default_nettype wire

[sv/altitude_average_and_setpoint_core.sv]
// top level of the altitude average and setpoint core
//
//   channel  ports                    direction  carries
//   req      req_valid / req_ready    in         event: sample, setpoint change, landing step
//   rsp      rsp_valid / rsp_ready    out        mean, percent, setpoint, error, flags
//   csr      csr_valid / csr_ready    in         register index and write data
//
// one request per cycle sustained while rsp is not stalled; every request gives one response
//   after acceptance, through state update, mean multiply, reference, scale, percent
//   multiply, saturate and output register
// the state update for a request happens at the queue head, so back-to-back
//   requests see each other's effect with no hazard
// synchronous active-high reset clears the sample ring, sums, counters,
//   setpoint, reference and both csr registers to their reset values
// a stalled rsp freezes the whole result pipeline; the two-entry queue keeps
//   req_ready high until it fills
`timescale 1ns / 1ps
`default_nettype none

module altitude_average_and_setpoint_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [aaas_pkg::CMD_W-1:0]            req_cmd,
   input  wire logic [aaas_pkg::SAMPLE_W-1:0]         req_sample_value,
   input  wire logic signed [aaas_pkg::DELTA_W-1:0]   req_setpoint_delta,
   input  wire logic [aaas_pkg::DESCENT_W-1:0]        req_descent_amount,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [aaas_pkg::MEAN_W-1:0]                rsp_mean_level,
   output logic signed [aaas_pkg::PCT_W-1:0]          rsp_height_percent,
   output logic [aaas_pkg::SETPOINT_W-1:0]            rsp_target_height,
   output logic signed [aaas_pkg::ERROR_W-1:0]        rsp_height_error,
   output logic                                       rsp_landed,
   output logic                                       rsp_reference_ready,
   // csr channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [aaas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [aaas_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import aaas_pkg::*;

   queue_status_type q_status;
   logic             push;
   item_type         push_item;
   logic             pop;
   logic             pop_valid;
   item_type         pop_item;

   // csr writes are always accepted and take effect in the next cycle
   assign csr_ready = 1'b1;

   // front: decode request into an operation and push it
   aaas_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_sample_value   (req_sample_value),
      .req_setpoint_delta (req_setpoint_delta),
      .req_descent_amount (req_descent_amount),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item)
   );

   // decoupling queue between decode and execution
   aaas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // back: running-sum state, setpoint logic and result pipeline
   aaas_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .pop_valid           (pop_valid),
      .pop_item            (pop_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_level      (rsp_mean_level),
      .rsp_height_percent  (rsp_height_percent),
      .rsp_target_height   (rsp_target_height),
      .rsp_height_error    (rsp_height_error),
      .rsp_landed          (rsp_landed),
      .rsp_reference_ready (rsp_reference_ready)
   );

   // ---------------- checks ----------------

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("request queue count above depth");

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full request queue");

   // landed only reported at zero setpoint and zero error
   a_landed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_landed) |-> (rsp_target_height == '0 && rsp_height_error == '0))
      else $error("landed flag with nonzero setpoint or error");

   // once the reference is latched it stays latched on later responses
   a_ref_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_reference_ready) |=> (!rsp_valid || rsp_reference_ready))
      else $error("reference ready dropped after latching");

endmodule

`default_nettype wire

[bench/altitude_average_and_setpoint_checker.sv]
// channel monitor, behavioral predictor and response scoreboard for the altitude core
`timescale 1ns / 1ps

module altitude_average_and_setpoint_checker
   import aaas_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [CMD_W-1:0]              req_cmd,
   input  wire logic [SAMPLE_W-1:0]           req_sample_value,
   input  wire logic signed [DELTA_W-1:0]     req_setpoint_delta,
   input  wire logic [DESCENT_W-1:0]          req_descent_amount,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [MEAN_W-1:0]             rsp_mean_level,
   input  wire logic signed [PCT_W-1:0]       rsp_height_percent,
   input  wire logic [SETPOINT_W-1:0]         rsp_target_height,
   input  wire logic signed [ERROR_W-1:0]     rsp_height_error,
   input  wire logic                          rsp_landed,
   input  wire logic                          rsp_reference_ready,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   output int                                 failures,
   output int                                 pending
);

   typedef struct packed {
      logic [MEAN_W-1:0]          mean;
      logic signed [PCT_W-1:0]    percent;
      logic [SETPOINT_W-1:0]      target;
      logic signed [ERROR_W-1:0]  error;
      logic                       landed;
      logic                       ground_ready;
   } reading_type;

   reading_type        expected_readings[$];

   // mirror of the block state
   logic [SAMPLE_W-1:0] level_ring [WINDOW_LEN];
   int unsigned         ring_slot;
   int unsigned         window_total;
   int unsigned         mean_now;
   int unsigned         seen_count;
   int unsigned         ground_level;
   bit                  ground_latched;
   int                  target_now;
   int unsigned         clamp_limit;
   int unsigned         settle_count;

   function automatic void clear_model();
      for (int i = 0; i < WINDOW_LEN; i++) level_ring[i] = '0;
      ring_slot      = 0;
      window_total   = 0;
      mean_now       = 0;
      seen_count     = 0;
      ground_level   = 0;
      ground_latched = 1'b0;
      target_now     = 0;
      clamp_limit    = ALTITUDE_MAX_RESET;
      settle_count   = SETTLE_RESET;
   endfunction

   // signed height above the latched ground, saturated to the port range
   function automatic int height_percent_now();
      int diff;
      int pct;
      diff = int'(ground_level) - int'(mean_now);
      pct  = (diff * int'(PCT_SCALE)) / int'(ADC_SPAN);
      if (pct > int'(PCT_POS_LIMIT)) pct = int'(PCT_POS_LIMIT);
      if (pct < -int'(PCT_NEG_LIMIT)) pct = -int'(PCT_NEG_LIMIT);
      return pct;
   endfunction

   function automatic reading_type predict_reading(
      input logic [CMD_W-1:0]          cmd,
      input logic [SAMPLE_W-1:0]       sample,
      input logic signed [DELTA_W-1:0] delta,
      input logic [DESCENT_W-1:0]      descent
   );
      reading_type r;
      int          s;
      int          pct;
      logic        land;
      land = 1'b0;
      case (cmd)
         CMD_SAMPLE: begin
            window_total = window_total - level_ring[ring_slot] + sample;
            level_ring[ring_slot] = sample;
            ring_slot = (ring_slot == WINDOW_LEN - 1) ? 0 : ring_slot + 1;
            mean_now = (2 * window_total + WINDOW_LEN) / (2 * WINDOW_LEN);
            if (seen_count < settle_count) seen_count++;
            if (!ground_latched && seen_count >= settle_count) begin
               ground_level   = mean_now;
               ground_latched = 1'b1;
            end
         end
         CMD_SETPOINT: begin
            s = target_now + int'(delta);
            if (s >= int'(clamp_limit)) s = int'(clamp_limit);
            else if (s < 0) s = 0;
            target_now = s;
         end
         CMD_DESCEND: begin
            if (target_now > 0) begin
               s = target_now - int'(descent);
               target_now = (s < 0) ? 0 : s;
            end else if (target_now - height_percent_now() == 0) begin
               land = 1'b1;
            end
         end
         default: ;
      endcase
      pct            = height_percent_now();
      r.mean         = mean_now[MEAN_W-1:0];
      r.percent      = pct[PCT_W-1:0];
      r.target       = target_now[SETPOINT_W-1:0];
      s              = target_now - pct;
      r.error        = s[ERROR_W-1:0];
      r.landed       = land;
      r.ground_ready = ground_latched;
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      reading_type want;
      reading_type got;
      if (reset) begin
         clear_model();
         expected_readings.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ALTITUDE_MAX) clamp_limit = csr_wdata[SETPOINT_W-1:0];
            else if (csr_index == CSR_SETTLE_SAMPLES) settle_count = csr_wdata[COUNT_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_mean_level, rsp_height_percent, rsp_target_height,
                    rsp_height_error, rsp_landed, rsp_reference_ready};
            if (expected_readings.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected response mean=%0d pct=%0d tgt=%0d err=%0d",
                           $realtime, got.mean, got.percent, got.target, got.error);
            end else begin
               want = expected_readings.pop_front();
               if (want !== got) begin
                  failures++;
                  if (failures <= 10)
                     $display({"%0t: mismatch exp mean=%0d pct=%0d tgt=%0d err=%0d land=%0b ",
                               "rdy=%0b got mean=%0d pct=%0d tgt=%0d err=%0d land=%0b rdy=%0b"},
                              $realtime, want.mean, want.percent, want.target, want.error,
                              want.landed, want.ground_ready, got.mean, got.percent,
                              got.target, got.error, got.landed, got.ground_ready);
               end
            end
         end
         if (req_valid && req_ready)
            expected_readings.push_back(predict_reading(req_cmd, req_sample_value,
                                                        req_setpoint_delta,
                                                        req_descent_amount));
      end
      pending = expected_readings.size();
   end

endmodule

[bench/altitude_average_and_setpoint_core_tb.sv]
// stimulus, flow control and verdict for the altitude average and setpoint core
`timescale 1ns / 1ps

module altitude_average_and_setpoint_core_tb;
   import aaas_pkg::*;

   // register indexes past the two real registers, writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;
   // the one command code the block does not act on
   localparam logic [CMD_W-1:0]       CMD_UNUSED    = 2'd3;
   // extremes of the signed setpoint change
   localparam logic [DELTA_W-1:0]     DELTA_UP_MAX   = 8'h7f;
   localparam logic [DELTA_W-1:0]     DELTA_DOWN_MAX = 8'h80;
   // full-scale sample, also the ground level latched by the directed part
   localparam logic [SAMPLE_W-1:0]    SAMPLE_FULL    = 12'hfff;
   // cycles with no handshake on any channel before the run is called hung
   localparam int                     QUIET_LIMIT    = 3000;
   localparam int                     PHASE_ITEMS    = 385;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [CMD_W-1:0]              req_cmd;
   logic [SAMPLE_W-1:0]           req_sample_value;
   logic signed [DELTA_W-1:0]     req_setpoint_delta;
   logic [DESCENT_W-1:0]          req_descent_amount;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [MEAN_W-1:0]             rsp_mean_level;
   logic signed [PCT_W-1:0]       rsp_height_percent;
   logic [SETPOINT_W-1:0]         rsp_target_height;
   logic signed [ERROR_W-1:0]     rsp_height_error;
   logic                          rsp_landed;
   logic                          rsp_reference_ready;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_wdata;

   int failures;
   int pending;
   int sender_idle_pct       = 0;
   int receiver_stall_pct    = 0;
   int receiver_hold_request = 0;
   int sent_count            = 0;
   int quiet_cycles          = 0;

   altitude_average_and_setpoint_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_sample_value    (req_sample_value),
      .req_setpoint_delta  (req_setpoint_delta),
      .req_descent_amount  (req_descent_amount),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_level      (rsp_mean_level),
      .rsp_height_percent  (rsp_height_percent),
      .rsp_target_height   (rsp_target_height),
      .rsp_height_error    (rsp_height_error),
      .rsp_landed          (rsp_landed),
      .rsp_reference_ready (rsp_reference_ready),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   altitude_average_and_setpoint_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_sample_value    (req_sample_value),
      .req_setpoint_delta  (req_setpoint_delta),
      .req_descent_amount  (req_descent_amount),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_level      (rsp_mean_level),
      .rsp_height_percent  (rsp_height_percent),
      .rsp_target_height   (rsp_target_height),
      .rsp_height_error    (rsp_height_error),
      .rsp_landed          (rsp_landed),
      .rsp_reference_ready (rsp_reference_ready),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .failures            (failures),
      .pending             (pending)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hang detector: any handshake on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls, plus a long hold-off on request from the
   // stimulus process, counted down here one falling edge at a time
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold_request > 0) begin
            hold_left             = receiver_hold_request;
            receiver_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_stall_pct == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   // one request: optional idle gap, then hold valid until the core takes it
   task automatic send_request(input logic [CMD_W-1:0]     cmd,
                               input logic [SAMPLE_W-1:0]  sample,
                               input logic [DELTA_W-1:0]   delta,
                               input logic [DESCENT_W-1:0] descent);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_sample_value   <= sample;
      req_setpoint_delta <= delta;
      req_descent_amount <= descent;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering, then wait for every outstanding response plus the
   // pipeline depth so the core is truly quiet
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   // registers only change with the core drained
   task automatic start_phase(input logic [CSR_DATA_W-1:0] clamp,
                              input logic [CSR_DATA_W-1:0] settle,
                              input int idle_pct, input int stall_pct);
      drain_results();
      write_register(CSR_ALTITUDE_MAX, clamp);
      write_register(CSR_SETTLE_SAMPLES, settle);
      @(posedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // mostly flights: settle the window near ground, climb, then descend in
   // steps toward the landing check; the rest is unstructured noise
   task automatic fly_random(input int count);
      int goal;
      int n;
      goal = sent_count + count;
      while (sent_count < goal) begin
         if ($urandom_range(99, 0) < 70) begin
            // hover readings close enough to ground that height reads zero
            n = $urandom_range(14, 10);
            for (int k = 0; k < n; k++)
               send_request(CMD_SAMPLE, $urandom_range(4095, 4084), $urandom_range(255, 0),
                            $urandom_range(127, 0));
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
               send_request(CMD_SETPOINT, $urandom_range(4095, 0), $urandom_range(127, 1),
                            $urandom_range(127, 0));
            n = $urandom_range(8, 2);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(99, 0) < 25)
                  send_request(CMD_SAMPLE, $urandom_range(4095, 4084), $urandom_range(255, 0),
                               $urandom_range(127, 0));
               else
                  send_request(CMD_DESCEND, $urandom_range(4095, 0), $urandom_range(255, 0),
                               $urandom_range(127, 0));
            end
         end else begin
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++)
               send_request($urandom_range(3, 0), $urandom_range(4095, 0),
                            $urandom_range(255, 0), $urandom_range(127, 0));
         end
      end
      // leave the setpoint high so a lowered clamp in the next phase has
      // something above it
      send_request(CMD_SETPOINT, '0, DELTA_UP_MAX, '0);
      send_request(CMD_SETPOINT, '0, DELTA_UP_MAX, '0);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = CMD_SAMPLE;
      req_sample_value   = '0;
      req_setpoint_delta = '0;
      req_descent_amount = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_ALTITUDE_MAX;
      csr_wdata          = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // phase 0: widest clamp, short settle so the ground latches early,
      // no flow control pressure
      start_phase(10'd255, 10'd12, 0, 0);

      // landing step at power-up: setpoint and error both zero
      send_request(CMD_DESCEND, '0, '0, '0);
      // unused command only reports
      send_request(CMD_UNUSED, SAMPLE_FULL, DELTA_DOWN_MAX, 7'h7f);
      // climb into the clamp, then back down through zero
      send_request(CMD_SETPOINT, '0, DELTA_UP_MAX, '0);
      send_request(CMD_SETPOINT, '0, DELTA_UP_MAX, '0);
      send_request(CMD_SETPOINT, '0, DELTA_UP_MAX, '0);
      send_request(CMD_SETPOINT, '0, DELTA_DOWN_MAX, '0);
      send_request(CMD_SETPOINT, '0, DELTA_DOWN_MAX, '0);
      // descent larger than the setpoint floors at zero, then lands
      send_request(CMD_SETPOINT, '0, 8'd100, '0);
      send_request(CMD_DESCEND, '0, '0, 7'h7f);
      send_request(CMD_DESCEND, '0, '0, '0);
      // zero sample then full scale: the ground latches on the twelfth
      // sample with the window full of full-scale readings
      send_request(CMD_SAMPLE, '0, '0, '0);
      for (int k = 0; k < 12; k++)
         send_request(CMD_SAMPLE, SAMPLE_FULL, '0, '0);
      // on the ground with zero height: landing again
      send_request(CMD_DESCEND, '0, '0, 7'd5);
      fly_random(PHASE_ITEMS);

      // phase 1: clamp of zero pins the setpoint, settle of zero, idle sender
      start_phase(10'd0, 10'd0, 57, 0);
      fly_random(PHASE_ITEMS);

      // phase 2: clamp of one, longest settle, stalling receiver;
      // writes to unused indexes must be dropped
      start_phase(10'd1, 10'd1023, 0, 57);
      write_register(CSR_UNUSED_LO, $urandom_range(1023, 0));
      write_register(CSR_UNUSED_HI, $urandom_range(1023, 0));
      fly_random(PHASE_ITEMS);

      // phase 3: reset-value clamp, settle of one, both sides idling;
      // halfway through the sender stops until the core has emptied
      start_phase(10'd100, 10'd1, 22, 22);
      fly_random(PHASE_ITEMS / 2);
      drain_results();
      fly_random(PHASE_ITEMS - PHASE_ITEMS / 2);

      // phase 4: random settings; the receiver holds off for a long stretch
      // while requests keep coming, so the queue fills and req_ready drops
      start_phase($urandom_range(255, 1), $urandom_range(1023, 1), 0, 0);
      @(posedge clock);
      receiver_hold_request = 300;
      fly_random(PHASE_ITEMS);

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
sv/aaas_pkg.sv
sv/aaas_front.sv
sv/aaas_queue.sv
sv/aaas_back.sv
sv/altitude_average_and_setpoint_core.sv
bench/altitude_average_and_setpoint_checker.sv
bench/altitude_average_and_setpoint_core_tb.sv
